[hw/rtl/usc_pkg.sv]
package usc_pkg;

    localparam int CDIV_STAGES = 3;

    localparam int SECS_W  = 32;
    localparam int DAYS_W  = 16;
    localparam int TOD_W   = 17;
    localparam int QUAD_W  = 6;
    localparam int QDAY_W  = 11;
    localparam int YINQ_W  = 2;
    localparam int DOY_W   = 9;
    localparam int HREM_W  = 12;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 8;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned DAYS_PER_QUAD = 1461;
    localparam int unsigned DAYS_PER_YEAR = 365;

    localparam int unsigned EPOCH_WEEKDAY   = 4;
    // day count is rebased to 1968-03-01 so each four-year group ends on Feb 29
    localparam int unsigned DAYS_TO_EPOCH   = 671;
    localparam int unsigned YEARS_TO_EPOCH  = 2;
    // 2100-03-01 as a day number; 2100 has no Feb 29, so skip one day from here
    localparam int unsigned DAY_MAR2100     = 47541;

    localparam longint unsigned DAY_Q_MAX  = 49710;
    localparam longint unsigned QUAD_Q_MAX = 34;
    localparam longint unsigned YEAR_Q_MAX = 3;
    localparam longint unsigned HOUR_Q_MAX = 23;
    localparam longint unsigned MIN_Q_MAX  = 59;

    localparam int MONTHS_PER_YEAR = 12;
    localparam int MON_JAN_MAR     = 10;
    localparam int MON_MAR_SHIFT   = 2;

    // first day of each month, March-based year
    function automatic logic [DOY_W-1:0] month_start(input logic [MON_W-1:0] m);
        case (m)
            MON_W'(0):  return DOY_W'(0);
            MON_W'(1):  return DOY_W'(31);
            MON_W'(2):  return DOY_W'(61);
            MON_W'(3):  return DOY_W'(92);
            MON_W'(4):  return DOY_W'(122);
            MON_W'(5):  return DOY_W'(153);
            MON_W'(6):  return DOY_W'(184);
            MON_W'(7):  return DOY_W'(214);
            MON_W'(8):  return DOY_W'(245);
            MON_W'(9):  return DOY_W'(275);
            MON_W'(10): return DOY_W'(306);
            MON_W'(11): return DOY_W'(337);
            default:    return DOY_W'(0);
        endcase
    endfunction

endpackage

[hw/rtl/usc_cdiv.sv]
module usc_cdiv #(
    parameter int              W_IN    = usc_pkg::SECS_W,
    parameter int unsigned     DIVISOR = usc_pkg::SECS_PER_DAY,
    parameter longint unsigned Q_MAX   = ((64'd1 << W_IN) - 64'd1) / DIVISOR
) (
    input  logic                                 i_clk,
    input  logic [usc_pkg::CDIV_STAGES-1:0]      i_en,
    input  logic [W_IN-1:0]                      i_x,
    output logic [$clog2(Q_MAX+1)-1:0]           o_q,
    output logic [$clog2(DIVISOR+1)-1:0]         o_r
);

    localparam int W_Q = $clog2(Q_MAX + 1);
    localparam int W_R = $clog2(DIVISOR + 1);
    localparam logic [W_IN-1:0] RECIP = W_IN'((65'd1 << W_IN) / 65'(DIVISOR));

    logic [2*W_IN-1:0] w_prod;
    logic [W_IN-1:0]   w_qd;
    logic [W_IN-1:0]   w_rem0;
    logic              w_fix;

    logic [W_IN-1:0]   r_x1;
    logic [W_Q-1:0]    r_q1;
    logic [W_R:0]      r_rem2;
    logic [W_Q-1:0]    r_q2;
    logic [W_Q-1:0]    r_q3;
    logic [W_R-1:0]    r_r3;

    // estimate is exact or one low
    assign w_prod = {{W_IN{1'b0}}, i_x} * {{W_IN{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x1 <= i_x;
            r_q1 <= W_Q'(w_prod >> W_IN);
        end
    end

    assign w_qd   = W_IN'(r_q1) * W_IN'(DIVISOR);
    assign w_rem0 = r_x1 - w_qd;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem2 <= w_rem0[W_R:0];
            r_q2   <= r_q1;
        end
    end

    // no step past the top quotient: lets the last remainder reach the divisor
    assign w_fix = (r_rem2 >= (W_R+1)'(DIVISOR)) && (r_q2 != W_Q'(Q_MAX));

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            if (w_fix) begin
                r_q3 <= r_q2 + W_Q'(1);
                r_r3 <= W_R'(r_rem2 - (W_R+1)'(DIVISOR));
            end else begin
                r_q3 <= r_q2;
                r_r3 <= r_rem2[W_R-1:0];
            end
        end
    end

    assign o_q = r_q3;
    assign o_r = r_r3;

endmodule

[hw/rtl/unix_seconds_to_calendar.sv]
// Throughput: one word per cycle while o_stall is low.
// The pipeline is twelve register stages.
// i_stall holds only the stages that carry a word; empty stages keep filling.
// Reset (synchronous, active low) clears the stage valid bits; data is not reset.
module unix_seconds_to_calendar (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [usc_pkg::SECS_W-1:0]    i_epoch_seconds,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [usc_pkg::YEAR_W-1:0]    o_year_offset,
    output logic [usc_pkg::MON_W-1:0]     o_month_index,
    output logic [usc_pkg::DAY_W-1:0]     o_day_index,
    output logic [usc_pkg::HOUR_W-1:0]    o_hour,
    output logic [usc_pkg::MIN_W-1:0]     o_minute,
    output logic [usc_pkg::SEC_W-1:0]     o_second,
    output logic [usc_pkg::WDAY_W-1:0]    o_weekday
);

    localparam int NSTG    = 12;
    localparam int ST_DAY  = 0;
    localparam int ST_PREP = 3;
    localparam int ST_DIV2 = 4;
    localparam int ST_DIV3 = 7;
    localparam int ST_MON  = 10;
    localparam int ST_OUT  = 11;
    localparam int NCMP    = usc_pkg::MONTHS_PER_YEAR - 1;

    typedef struct packed {
        logic [usc_pkg::QUAD_W-1:0] quad;
        logic [usc_pkg::HOUR_W-1:0] hour;
        logic [usc_pkg::WDAY_W-1:0] wday;
    } t_side;

    typedef struct packed {
        logic [usc_pkg::YEAR_W-1:0] ybase;
        logic [usc_pkg::MON_W-1:0]  mp;
        logic [usc_pkg::DOY_W-1:0]  doy;
        logic [usc_pkg::HOUR_W-1:0] hour;
        logic [usc_pkg::MIN_W-1:0]  minute;
        logic [usc_pkg::SEC_W-1:0]  second;
        logic [usc_pkg::WDAY_W-1:0] wday;
    } t_mon;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] n_v;
    logic [NSTG-1:0] w_en;

    logic [usc_pkg::DAYS_W-1:0] w_days;
    logic [usc_pkg::TOD_W-1:0]  w_tod;
    logic                       w_skip;

    logic [usc_pkg::DAYS_W-1:0] r_d;
    logic [usc_pkg::DAYS_W-1:0] r_wx;
    logic [usc_pkg::TOD_W-1:0]  r_tod;

    logic [usc_pkg::QUAD_W-1:0] w_quad;
    logic [usc_pkg::QDAY_W-1:0] w_qday;
    logic [usc_pkg::HOUR_W-1:0] w_hour;
    logic [usc_pkg::HREM_W-1:0] w_hrem;
    logic [usc_pkg::WDAY_W-1:0] w_wday;
    t_side                      w_side_in;
    t_side                      r_side [usc_pkg::CDIV_STAGES];

    logic [usc_pkg::YINQ_W-1:0] w_yinq;
    logic [usc_pkg::DOY_W-1:0]  w_doy;
    logic [usc_pkg::MIN_W-1:0]  w_min;
    logic [usc_pkg::SEC_W-1:0]  w_sec;
    logic [NCMP-1:0]            w_mcmp;
    t_mon                       w_mon;
    t_mon                       r_mon;

    logic                       w_late;
    logic [usc_pkg::YEAR_W-1:0] r_year_offset;
    logic [usc_pkg::MON_W-1:0]  r_month_index;
    logic [usc_pkg::DAY_W-1:0]  r_day_index;
    logic [usc_pkg::HOUR_W-1:0] r_hour;
    logic [usc_pkg::MIN_W-1:0]  r_minute;
    logic [usc_pkg::SEC_W-1:0]  r_second;
    logic [usc_pkg::WDAY_W-1:0] r_weekday;

    // a stage moves unless it and every stage after it are full and the output is stalled
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            w_en[k] = !i_stall || !(&(r_v | ((NSTG'(1) << k) - NSTG'(1))));
        end
    end

    always_comb begin
        n_v = r_v;
        if (w_en[0]) begin
            n_v[0] = i_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[ST_OUT];

    // seconds -> days, time of day
    usc_cdiv #(
        .W_IN    (usc_pkg::SECS_W),
        .DIVISOR (usc_pkg::SECS_PER_DAY),
        .Q_MAX   (usc_pkg::DAY_Q_MAX)
    ) u_day (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DAY +: usc_pkg::CDIV_STAGES]),
        .i_x   (i_epoch_seconds),
        .o_q   (w_days),
        .o_r   (w_tod)
    );

    assign w_skip = w_days >= usc_pkg::DAYS_W'(usc_pkg::DAY_MAR2100);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PREP]) begin
            r_d   <= w_days + usc_pkg::DAYS_W'(usc_pkg::DAYS_TO_EPOCH)
                     + usc_pkg::DAYS_W'(w_skip);
            r_wx  <= w_days + usc_pkg::DAYS_W'(usc_pkg::EPOCH_WEEKDAY);
            r_tod <= w_tod;
        end
    end

    usc_cdiv #(
        .W_IN    (usc_pkg::DAYS_W),
        .DIVISOR (usc_pkg::DAYS_PER_QUAD),
        .Q_MAX   (usc_pkg::QUAD_Q_MAX)
    ) u_quad (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DIV2 +: usc_pkg::CDIV_STAGES]),
        .i_x   (r_d),
        .o_q   (w_quad),
        .o_r   (w_qday)
    );

    usc_cdiv #(
        .W_IN    (usc_pkg::TOD_W),
        .DIVISOR (usc_pkg::SECS_PER_HOUR),
        .Q_MAX   (usc_pkg::HOUR_Q_MAX)
    ) u_hour (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DIV2 +: usc_pkg::CDIV_STAGES]),
        .i_x   (r_tod),
        .o_q   (w_hour),
        .o_r   (w_hrem)
    );

    usc_cdiv #(
        .W_IN    (usc_pkg::DAYS_W),
        .DIVISOR (usc_pkg::DAYS_PER_WEEK)
    ) u_week (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DIV2 +: usc_pkg::CDIV_STAGES]),
        .i_x   (r_wx),
        .o_q   (),
        .o_r   (w_wday)
    );

    assign w_side_in = '{quad: w_quad, hour: w_hour, wday: w_wday};

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIV3]) begin
            r_side[0] <= w_side_in;
        end
        for (int i = 1; i < usc_pkg::CDIV_STAGES; i++) begin
            if (w_en[ST_DIV3 + i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // year within the group; the last day of the group stays in year three
    usc_cdiv #(
        .W_IN    (usc_pkg::QDAY_W),
        .DIVISOR (usc_pkg::DAYS_PER_YEAR),
        .Q_MAX   (usc_pkg::YEAR_Q_MAX)
    ) u_year (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DIV3 +: usc_pkg::CDIV_STAGES]),
        .i_x   (w_qday),
        .o_q   (w_yinq),
        .o_r   (w_doy)
    );

    usc_cdiv #(
        .W_IN    (usc_pkg::HREM_W),
        .DIVISOR (usc_pkg::SECS_PER_MIN),
        .Q_MAX   (usc_pkg::MIN_Q_MAX)
    ) u_min (
        .i_clk (i_clk),
        .i_en  (w_en[ST_DIV3 +: usc_pkg::CDIV_STAGES]),
        .i_x   (w_hrem),
        .o_q   (w_min),
        .o_r   (w_sec)
    );

    always_comb begin
        for (int k = 1; k <= NCMP; k++) begin
            w_mcmp[k-1] = w_doy >= usc_pkg::month_start(usc_pkg::MON_W'(k));
        end
    end

    always_comb begin
        w_mon.ybase  = usc_pkg::YEAR_W'({r_side[usc_pkg::CDIV_STAGES-1].quad, 2'b00})
                       + usc_pkg::YEAR_W'(w_yinq)
                       - usc_pkg::YEAR_W'(usc_pkg::YEARS_TO_EPOCH);
        w_mon.mp     = usc_pkg::MON_W'($countones(w_mcmp));
        w_mon.doy    = w_doy;
        w_mon.hour   = r_side[usc_pkg::CDIV_STAGES-1].hour;
        w_mon.minute = w_min;
        w_mon.second = w_sec;
        w_mon.wday   = r_side[usc_pkg::CDIV_STAGES-1].wday;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MON]) begin
            r_mon <= w_mon;
        end
    end

    // January and February close the March-based year
    assign w_late = r_mon.mp >= usc_pkg::MON_W'(usc_pkg::MON_JAN_MAR);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_year_offset <= r_mon.ybase + usc_pkg::YEAR_W'(w_late);
            if (w_late) begin
                r_month_index <= r_mon.mp - usc_pkg::MON_W'(usc_pkg::MON_JAN_MAR);
            end else begin
                r_month_index <= r_mon.mp + usc_pkg::MON_W'(usc_pkg::MON_MAR_SHIFT);
            end
            r_day_index <= usc_pkg::DAY_W'(r_mon.doy - usc_pkg::month_start(r_mon.mp));
            r_hour      <= r_mon.hour;
            r_minute    <= r_mon.minute;
            r_second    <= r_mon.second;
            r_weekday   <= r_mon.wday;
        end
    end

    assign o_year_offset = r_year_offset;
    assign o_month_index = r_month_index;
    assign o_day_index   = r_day_index;
    assign o_hour        = r_hour;
    assign o_minute      = r_minute;
    assign o_second      = r_second;
    assign o_weekday     = r_weekday;

endmodule
